### src/ltric_pkg.sv
package ltric_pkg;

  localparam int DATA_W = 32;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam int CNT_W = $clog2(DATA_W);

  // Operator and digit characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_POW     = 3'd5,
    OP_UNKNOWN = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_MID,
    S_RUN_MID,
    S_START_END,
    S_RUN_END,
    S_OUT
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic alu_start;
    logic commit_mid;
    logic commit_end;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_digit;
    logic in_last;
    logic alu_done;
  } dp_stat_t;

  function automatic op_t decode_op(logic [CHAR_W-1:0] c);
    op_t op;
    unique case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_CARET: op = OP_POW;
      default:  op = OP_UNKNOWN;
    endcase
    return op;
  endfunction

endpackage

### src/ltric_ifs.sv
interface ltric_char_if;
  logic                               valid;
  logic                               ready;
  logic [ltric_pkg::CHAR_W-1:0]       char_code;
  logic                               end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface ltric_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [ltric_pkg::DATA_W-1:0] value;
  logic                               div_zero;

  modport source (output valid, output value, output div_zero, input ready);
  modport sink   (input valid, input value, input div_zero, output ready);
endinterface

### src/ltric_alu.sv
module ltric_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  ltric_pkg::op_t               op,
  input  logic [ltric_pkg::DATA_W-1:0] a,
  input  logic [ltric_pkg::DATA_W-1:0] b,
  output logic                         done,
  output logic [ltric_pkg::DATA_W-1:0] result,
  output logic                         dz
);

  localparam int W = ltric_pkg::DATA_W;

  logic [W-1:0]                  res;
  logic [W-1:0]                  sq;
  logic [W-1:0]                  ex;
  logic [W-1:0]                  quo;
  logic [W-1:0]                  rem;
  logic [W-1:0]                  dvs;
  logic                          neg;
  logic [ltric_pkg::CNT_W-1:0]   cnt;
  logic                          mul_busy;
  logic                          div_busy;
  logic                          fix;

  logic [W-1:0]                  mul_res;
  logic [W-1:0]                  mul_sq;
  logic [W:0]                    trial;
  logic [W-1:0]                  mag_a;
  logic [W-1:0]                  mag_b;
  logic [W-1:0]                  pow_neg;

  // Shared multipliers: accumulate and square, each registered
  assign mul_res = res * sq;
  assign mul_sq  = sq * sq;

  // One restoring divide step
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  assign mag_a = a[W-1] ? (W'(0) - a) : a;
  assign mag_b = b[W-1] ? (W'(0) - b) : b;

  // Power with a negative exponent
  always_comb begin
    if (a == W'(1)) begin
      pow_neg = W'(1);
    end else if (a == {W{1'b1}}) begin
      pow_neg = b[0] ? {W{1'b1}} : W'(1);
    end else begin
      pow_neg = '0;
    end
  end

  // Sequencing flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      fix      <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      fix  <= 1'b0;
      if (start) begin
        case (op)
          ltric_pkg::OP_MUL: mul_busy <= 1'b1;
          ltric_pkg::OP_POW: begin
            if (b[W-1]) begin
              done <= 1'b1;
            end else begin
              mul_busy <= 1'b1;
            end
          end
          ltric_pkg::OP_DIV: begin
            if (b == '0) begin
              done <= 1'b1;
            end else begin
              div_busy <= 1'b1;
            end
          end
          default: done <= 1'b1;
        endcase
      end else if (mul_busy) begin
        if (ex == '0) begin
          mul_busy <= 1'b0;
          done     <= 1'b1;
        end
      end else if (div_busy) begin
        if (cnt == {ltric_pkg::CNT_W{1'b1}}) begin
          div_busy <= 1'b0;
          fix      <= 1'b1;
        end
      end else if (fix) begin
        done <= 1'b1;
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      dz  <= 1'b0;
      cnt <= '0;
      case (op)
        ltric_pkg::OP_NONE: res <= b;
        ltric_pkg::OP_ADD:  res <= a + b;
        ltric_pkg::OP_SUB:  res <= a - b;
        ltric_pkg::OP_MUL: begin
          res <= a;
          sq  <= b;
          ex  <= W'(1);
        end
        ltric_pkg::OP_POW: begin
          res <= b[W-1] ? pow_neg : W'(1);
          sq  <= a;
          ex  <= b;
        end
        ltric_pkg::OP_DIV: begin
          res <= '0;
          dz  <= (b == '0);
          quo <= mag_a;
          dvs <= mag_b;
          rem <= '0;
          neg <= a[W-1] ^ b[W-1];
        end
        default: res <= {W{1'b1}};
      endcase
    end else if (mul_busy) begin
      // Square-and-multiply, one exponent bit per cycle
      if (ex != '0) begin
        if (ex[0]) begin
          res <= mul_res;
        end
        sq <= mul_sq;
        ex <= ex >> 1;
      end
    end else if (div_busy) begin
      cnt <= cnt + 1'b1;
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end else if (fix) begin
      res <= neg ? (W'(0) - quo) : quo;
    end
  end

  assign result = res;

endmodule

### src/ltric_dp.sv
module ltric_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ltric_pkg::CHAR_W-1:0]  char_code,
  input  logic                          end_of_expr,
  input  ltric_pkg::dp_cmd_t            cmd,
  output ltric_pkg::dp_stat_t           stat,
  output logic [ltric_pkg::DATA_W-1:0]  value,
  output logic                          div_zero
);

  localparam int W = ltric_pkg::DATA_W;

  logic [W-1:0]                    acc;
  logic [W-1:0]                    operand;
  ltric_pkg::op_t                  pending;
  ltric_pkg::op_t                  new_op;
  logic                            zdiv;
  logic [W-1:0]                    out_value;
  logic                            out_dz;

  logic [ltric_pkg::CHAR_W-1:0]    digit_code;
  logic [W-1:0]                    operand_next;
  logic                            alu_done;
  logic [W-1:0]                    alu_result;
  logic                            alu_dz;

  ltric_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.alu_start),
    .op     (pending),
    .a      (acc),
    .b      (operand),
    .done   (alu_done),
    .result (alu_result),
    .dz     (alu_dz)
  );

  // Decode the incoming character
  assign digit_code = char_code - ltric_pkg::CH_ZERO;
  assign operand_next = (operand << 3) + (operand << 1) + W'(digit_code[ltric_pkg::DIGIT_W-1:0]);

  assign stat.in_digit = (char_code >= ltric_pkg::CH_ZERO) && (char_code <= ltric_pkg::CH_NINE);
  assign stat.in_last  = end_of_expr;
  assign stat.alu_done = alu_done;

  // Expression state
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      acc     <= '0;
      operand <= '0;
      pending <= ltric_pkg::OP_NONE;
      zdiv    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (stat.in_digit) begin
          operand <= operand_next;
        end
      end
      if (cmd.commit_mid) begin
        acc     <= alu_result;
        pending <= new_op;
        operand <= '0;
        zdiv    <= zdiv | alu_dz;
      end
      if (cmd.commit_end) begin
        acc  <= alu_result;
        zdiv <= zdiv | alu_dz;
      end
    end
  end

  // Hold the operator of the item until the pending one is applied
  always_ff @(posedge clk) begin
    if (cmd.accept && !stat.in_digit) begin
      new_op <= ltric_pkg::decode_op(char_code);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value <= acc;
      out_dz    <= zdiv;
    end
  end

  assign value    = out_value;
  assign div_zero = out_dz;

endmodule

### src/ltric_ctrl.sv
module ltric_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ltric_pkg::dp_stat_t stat,
  output ltric_pkg::dp_cmd_t  cmd
);

  ltric_pkg::ctrl_state_t state;
  ltric_pkg::ctrl_state_t state_next;
  logic                   last_flag;
  logic                   out_valid_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ltric_pkg::S_IDLE;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cmd.accept) begin
        last_flag <= stat.in_last;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ltric_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!stat.in_digit) begin
            state_next = ltric_pkg::S_START_MID;
          end else if (stat.in_last) begin
            state_next = ltric_pkg::S_START_END;
          end
        end
      end
      ltric_pkg::S_START_MID: state_next = ltric_pkg::S_RUN_MID;
      ltric_pkg::S_RUN_MID: begin
        if (stat.alu_done) begin
          state_next = last_flag ? ltric_pkg::S_START_END : ltric_pkg::S_IDLE;
        end
      end
      ltric_pkg::S_START_END: state_next = ltric_pkg::S_RUN_END;
      ltric_pkg::S_RUN_END: begin
        if (stat.alu_done) begin
          state_next = ltric_pkg::S_OUT;
        end
      end
      ltric_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ltric_pkg::S_IDLE;
        end
      end
      default: state_next = ltric_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state) inside
      ltric_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ltric_pkg::S_START_MID, ltric_pkg::S_START_END: cmd.alu_start = 1'b1;
      ltric_pkg::S_RUN_MID: cmd.commit_mid = stat.alu_done;
      ltric_pkg::S_RUN_END: cmd.commit_end = stat.alu_done;
      ltric_pkg::S_OUT:     cmd.load_out   = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### src/left_to_right_integer_calculator.sv
// A digit item extends the operand. An operator item applies the pending operator: + - and
// unknown codes directly, * by one multiply, / by a restoring divide (one quotient bit per
// cycle, then a sign fix; not on a zero divisor) and ^ by square-and-multiply over the
// exponent bits (not for a negative exponent). A last item then runs the pending operator on
// the final operand and loads the result register, which waits while an earlier result is
// untaken. One item in work at a time; reset (rst, synchronous, active high) clears state and valid.
module left_to_right_integer_calculator (
  input  logic           clk,
  input  logic           rst,
  ltric_char_if.sink     chars,
  ltric_result_if.source results
);

  ltric_pkg::dp_cmd_t                cmd;
  ltric_pkg::dp_stat_t               stat;
  logic [ltric_pkg::DATA_W-1:0]      value;

  ltric_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ltric_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .char_code   (chars.char_code),
    .end_of_expr (chars.end_of_expr),
    .cmd         (cmd),
    .stat        (stat),
    .value       (value),
    .div_zero    (results.div_zero)
  );

  assign results.value = value;

  // Commit only a finished operation
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_mid || cmd.commit_end) |-> stat.alu_done)
    else $error("commit without a finished operation");

  // Take no item while an operation runs
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.alu_start |=> !chars.ready)
    else $error("input ready while an operation runs");

  // Never overwrite a result that waits to be taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("result register overwritten");

  // A new result appears only after a load
  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ltric_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     div_zero;
  } calc_result_t;

  // One directed item, with an optional hand-written result on the last item
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] value;
    logic              div_zero;
  } char_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ltric_char_if   char_bus ();
  ltric_result_if res_bus ();

  left_to_right_integer_calculator dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus),
    .results (res_bus)
  );

  // Evaluator state mirrored on the testbench side
  logic [DATA_W-1:0] calc_acc     = '0;
  logic [DATA_W-1:0] calc_operand = '0;
  op_t               calc_op      = OP_NONE;
  logic              calc_op_seen = 1'b0;
  logic              calc_dz_seen = 1'b0;

  calc_result_t pending_values[$];
  char_row_t    directed_rows[$];
  calc_result_t head_result;

  int   items_sent  = 0;
  int   burst_left  = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  logic long_hold   = 1'b0;
  logic [7:0] stall_mask = 8'hFF;
  int   mask_left   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one operator to the accumulator and the finished operand
  function automatic logic [DATA_W-1:0] apply_op(op_t op, logic [DATA_W-1:0] a,
                                                 logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] sq;
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == '0) begin
          calc_dz_seen = 1'b1;
          return '0;
        end
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        q  = ma / mb;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
      end
      OP_POW: begin
        // negative exponent: only 1 and -1 survive
        if (b[DATA_W-1]) begin
          if (a == 1) return 1;
          if (a == '1) return b[0] ? '1 : 1;
          return '0;
        end
        r  = 1;
        sq = a;
        for (int i = 0; i < DATA_W - 1; i++) begin
          if (b[i]) r = r * sq;
          sq = sq * sq;
        end
        return r;
      end
      default: return '1;
    endcase
  endfunction

  // Offer one item, wait for the handshake, then advance the mirrored state
  task automatic send_char(logic [CHAR_W-1:0] code, logic last, logic typed,
                           logic [DATA_W-1:0] tvalue, logic tdz);
    int gap;
    calc_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_bus.valid       <= 1'b1;
    char_bus.char_code   <= code;
    char_bus.end_of_expr <= last;
    do @(posedge clk); while (!(char_bus.valid && char_bus.ready));
    items_sent++;

    if (code >= CH_ZERO && code <= CH_NINE) begin
      calc_operand = calc_operand * 10 + DATA_W'(code - CH_ZERO);
    end else begin
      calc_acc = calc_op_seen ? apply_op(calc_op, calc_acc, calc_operand) : calc_operand;
      calc_op_seen = 1'b1;
      case (code)
        CH_PLUS:  calc_op = OP_ADD;
        CH_MINUS: calc_op = OP_SUB;
        CH_STAR:  calc_op = OP_MUL;
        CH_SLASH: calc_op = OP_DIV;
        CH_CARET: calc_op = OP_POW;
        default:  calc_op = OP_UNKNOWN;
      endcase
      calc_operand = '0;
    end

    if (last) begin
      res.value    = calc_op_seen ? apply_op(calc_op, calc_acc, calc_operand) : calc_operand;
      res.div_zero = calc_dz_seen;
      if (typed) begin
        res.value    = tvalue;
        res.div_zero = tdz;
      end
      pending_values.insert(pending_values.size(), res);
      calc_acc     = '0;
      calc_operand = '0;
      calc_op      = OP_NONE;
      calc_op_seen = 1'b0;
      calc_dz_seen = 1'b0;
    end
  endtask

  // Append a string of characters; the final one carries the end mark if asked
  task automatic add_text(string s, logic last, logic typed, logic [DATA_W-1:0] v,
                          logic dz);
    char_row_t row;
    for (int i = 0; i < s.len(); i++) begin
      row.code     = s[i];
      row.last     = last && (i == s.len() - 1);
      row.typed    = typed && (i == s.len() - 1);
      row.value    = v;
      row.div_zero = dz;
      directed_rows.insert(directed_rows.size(), row);
    end
  endtask

  // Stimulus: directed table, then random expressions
  initial begin
    logic [CHAR_W-1:0] expr_chars[$];
    logic [CHAR_W-1:0] odd_code;
    char_row_t row;
    string fixed;
    int n_terms;
    int kind;
    int total_items;

    char_bus.valid       = 1'b0;
    char_bus.char_code   = '0;
    char_bus.end_of_expr = 1'b0;
    res_bus.ready        = 1'b0;

    // lone number, most negative over minus one, divide by zero, zero to the zero,
    // then a plus with an empty trailing operand closed by an unknown code
    add_text("9", 1'b1, 1'b1, 32'd9, 1'b0);
    add_text("-2^31/4294967295", 1'b1, 1'b1, 32'h8000_0000, 1'b0);
    add_text("7/0", 1'b1, 1'b1, 32'd0, 1'b1);
    add_text("0^0", 1'b1, 1'b1, 32'd1, 1'b0);
    add_text("6*7+", 1'b0, 1'b0, '0, 1'b0);
    row.code     = 8'hFF;
    row.last     = 1'b1;
    row.typed    = 1'b1;
    row.value    = 32'hFFFF_FFFF;
    row.div_zero = 1'b0;
    directed_rows.insert(directed_rows.size(), row);
    total_items = directed_rows.size() + RANDOM_ITEMS;

    while (rst) @(posedge clk);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].value, directed_rows[i].div_zero);
    end

    while (items_sent < total_items) begin
      n_terms = $urandom_range(1, 5);
      for (int t = 0; t < n_terms; t++) begin
        // operand: mostly short, sometimes empty or ten digits that wrap
        kind  = $urandom_range(0, 15);
        fixed = "";
        case (kind)
          0: ;
          1: repeat (10)
            expr_chars.insert(expr_chars.size(), CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
          2: fixed = "4294967295";
          3: fixed = "2147483648";
          default: begin
            repeat ($urandom_range(1, 3))
              expr_chars.insert(expr_chars.size(), CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
          end
        endcase
        for (int i = 0; i < fixed.len(); i++) expr_chars.insert(expr_chars.size(), fixed[i]);

        if (t < n_terms - 1 || $urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 11))
            0, 1:    expr_chars.insert(expr_chars.size(), CH_PLUS);
            2, 3:    expr_chars.insert(expr_chars.size(), CH_MINUS);
            4, 5:    expr_chars.insert(expr_chars.size(), CH_STAR);
            6, 7:    expr_chars.insert(expr_chars.size(), CH_SLASH);
            8, 9:    expr_chars.insert(expr_chars.size(), CH_CARET);
            default: begin
              do odd_code = CHAR_W'($urandom_range(0, 255));
              while (odd_code >= CH_ZERO && odd_code <= CH_NINE);
              expr_chars.insert(expr_chars.size(), odd_code);
            end
          endcase
        end
      end
      if (expr_chars.size() == 0) expr_chars.insert(0, CHAR_W'(CH_ZERO + $urandom_range(0, 9)));

      // corrupt one character now and then
      if ($urandom_range(0, 9) == 0)
        expr_chars[$urandom_range(0, expr_chars.size() - 1)] = CHAR_W'($urandom_range(0, 255));

      foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0, 1'b0);
      expr_chars.delete();
    end
    char_bus.valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hold the result side off long enough for the input to back up
  initial begin
    wait (items_sent >= HOLD_AT_ITEM);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Check each result item, then pick the next ready from a rotating stall mask
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_values.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result: value=%0d div_zero=%0b", res_bus.value,
                   res_bus.div_zero);
      end else begin
        head_result = pending_values.pop_front();
        if (res_bus.value !== head_result.value) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("value mismatch: expected %0d, got %0d", head_result.value,
                     res_bus.value);
        end
        if (res_bus.div_zero !== head_result.div_zero) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("div_zero mismatch: expected %0b, got %0b", head_result.div_zero,
                     res_bus.div_zero);
        end
      end
    end

    if (mask_left == 0) begin
      mask_left <= $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       stall_mask <= 8'hFF;
        1:       stall_mask <= 8'($urandom);
        default: stall_mask <= 8'($urandom | $urandom);
      endcase
    end else begin
      mask_left  <= mask_left - 1;
      stall_mask <= {stall_mask[6:0], stall_mask[7]};
    end
    res_bus.ready <= !long_hold && stall_mask[0];
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
